// File: hdl/first_order_tustin_filter_unit_assert.svh
// Assertion macros for the first-order Tustin filter unit.
// Included by the top level; the bodies are empty in synthesis builds.
`ifndef FIRST_ORDER_TUSTIN_FILTER_UNIT_ASSERT_SVH
`define FIRST_ORDER_TUSTIN_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FOTF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FOTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FOTF_ASSERT(lbl, clk, rstn, prop, msg)
`define FOTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: hdl/fotf_pkg.sv
// Shared types and constants of the first-order Tustin filter unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package fotf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CoefW   = 35;
  localparam int unsigned ProdW   = CoefW + DataW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned DivBits = 32;
  localparam int unsigned CntW    = $clog2(DivBits);
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DataW-1:0] RstCoefA    = 32'd65536;
  localparam logic [DataW-1:0] RstCoefB    = 32'd65536;
  localparam logic [DataW-1:0] RstCoefC    = 32'd0;
  localparam logic [DataW-1:0] RstCoefD    = 32'd65536;
  localparam logic [DataW-1:0] RstStepTime = 32'd4294967;
  localparam logic [DataW-1:0] RstInitIn   = 32'd0;
  localparam logic [DataW-1:0] RstInitOut  = 32'd0;

  localparam logic [DataW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A    = 3'd0,
    REG_COEF_B    = 3'd1,
    REG_COEF_C    = 3'd2,
    REG_COEF_D    = 3'd3,
    REG_STEP_TIME = 3'd4,
    REG_INIT_IN   = 3'd5,
    REG_INIT_OUT  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] coef_a;
    logic signed [DataW-1:0] coef_b;
    logic signed [DataW-1:0] coef_c;
    logic signed [DataW-1:0] coef_d;
    logic        [DataW-1:0] step_time;
    logic signed [DataW-1:0] initial_input;
    logic signed [DataW-1:0] initial_output;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DT,
    ST_COEF,
    ST_MUL,
    ST_SUM,
    ST_ABS,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } fsm_state_e;

  typedef struct packed {
    logic load_in;
    logic calc_dt;
    logic calc_coef;
    logic calc_mul;
    logic calc_sum;
    logic calc_abs;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/first_order_tustin_filter_unit.sv
// First-order Tustin filter: each word runs through the dt, coefficient, multiply,
// sum, magnitude, check, divide and finish states (a zero denominator skips to finish);
// one word at a time; the 32-step radix-2 divider forms the quotient one bit per cycle.
// A finished word waits in the output register while the next input is taken.
// Reset (asynchronous, active low) loads the register defaults and clears the
// filter state to the initial input and output values.
`default_nettype none
`include "first_order_tustin_filter_unit_assert.svh"
module first_order_tustin_filter_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [fotf_pkg::DataW-1:0]   s_axis_tdata,   // [31:0] sample_in
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [fotf_pkg::DataW-1:0]        m_axis_tdata,   // [31:0] sample_out
  output logic [1:0]                        m_axis_tuser,   // [0] saturated, [1] bad_divisor
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fotf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fotf_pkg::DataW-1:0]   cfg_data_i
);
  import fotf_pkg::*;

  cfg_t cfg;
  logic reload;
  cmd_t cmd;
  sts_t sts;
  logic in_acc;
  logic busy;
  logic bad_ok;

  fotf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .reload_o    (reload)
  );

  fotf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fotf_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .reload_i      (reload),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_in_i   (s_axis_tdata),
    .sample_out_o  (m_axis_tdata),
    .saturated_o   (m_axis_tuser[0]),
    .bad_divisor_o (m_axis_tuser[1])
  );

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign busy   = cmd.div_step || cmd.finish;
  assign bad_ok = !(m_axis_tvalid && m_axis_tuser[1]) ||
                  (m_axis_tdata == '0 && !m_axis_tuser[0]);

  `FOTF_ASSERT(a_ready_not_busy, clk_i, rst_ni, !(s_axis_tready && busy), "ready while busy")
  `FOTF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready, "second word")
  `FOTF_ASSERT_NEXT(a_finish_shows_word, clk_i, rst_ni, cmd.finish, m_axis_tvalid, "word hidden")
  `FOTF_ASSERT(a_bad_divisor_zero, clk_i, rst_ni, bad_ok, "bad divisor word not zero")

endmodule
`default_nettype wire

// File: hdl/fotf_cfg.sv
// Configuration register file of the first-order Tustin filter unit.
// Depends on fotf_pkg; pulses a state reload after each valid write to a defined register.
`default_nettype none
module fotf_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fotf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fotf_pkg::DataW-1:0]   cfg_data_i,
  output fotf_pkg::cfg_t                    cfg_o,
  output logic                              reload_o
);
  import fotf_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic reload_q, reload_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d    = cfg_q;
    reload_d = 1'b0;
    if (wr) begin
      reload_d = 1'b1;
      unique case (cfg_index_i)
        REG_COEF_A:    cfg_d.coef_a         = cfg_data_i;
        REG_COEF_B:    cfg_d.coef_b         = cfg_data_i;
        REG_COEF_C:    cfg_d.coef_c         = cfg_data_i;
        REG_COEF_D:    cfg_d.coef_d         = cfg_data_i;
        REG_STEP_TIME: cfg_d.step_time      = cfg_data_i;
        REG_INIT_IN:   cfg_d.initial_input  = cfg_data_i;
        REG_INIT_OUT:  cfg_d.initial_output = cfg_data_i;
        default:       reload_d             = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a         <= RstCoefA;
      cfg_q.coef_b         <= RstCoefB;
      cfg_q.coef_c         <= RstCoefC;
      cfg_q.coef_d         <= RstCoefD;
      cfg_q.step_time      <= RstStepTime;
      cfg_q.initial_input  <= RstInitIn;
      cfg_q.initial_output <= RstInitOut;
      reload_q             <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      reload_q <= reload_d;
    end
  end

  assign cfg_o    = cfg_q;
  assign reload_o = reload_q;

endmodule
`default_nettype wire

// File: hdl/fotf_ctrl.sv
// Sequencing state machine of the first-order Tustin filter unit.
// Depends on fotf_pkg; drives datapath commands and the output valid.
`default_nettype none
module fotf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire fotf_pkg::sts_t sts_i,
  output fotf_pkg::cmd_t      cmd_o
);
  import fotf_pkg::*;

  fsm_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DT;
        end
      end
      ST_DT: begin
        cmd_o.calc_dt = 1'b1;
        state_d       = ST_COEF;
      end
      ST_COEF: begin
        cmd_o.calc_coef = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = sts_i.den_zero ? ST_FIN : ST_SUM;
      end
      ST_SUM: begin
        cmd_o.calc_sum = 1'b1;
        state_d        = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.calc_abs = 1'b1;
        state_d        = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivBits - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: hdl/fotf_dpath.sv
// Arithmetic datapath of the first-order Tustin filter unit: dt products,
// coefficients, weighted sum, restoring divider and saturation. Uses fotf_pkg.
`default_nettype none
module fotf_dpath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fotf_pkg::cfg_t             cfg_i,
  input  wire logic                       reload_i,
  input  wire fotf_pkg::cmd_t             cmd_i,
  output fotf_pkg::sts_t                  sts_o,
  input  wire logic [fotf_pkg::DataW-1:0] sample_in_i,
  output logic [fotf_pkg::DataW-1:0]      sample_out_o,
  output logic                            saturated_o,
  output logic                            bad_divisor_o
);
  import fotf_pkg::*;

  logic signed [DataW-1:0] prev_in_q, prev_in_d;
  logic signed [DataW-1:0] prev_out_q, prev_out_d;
  logic signed [DataW-1:0] x_q;

  logic [DataW-1:0]   bmag, dmul;
  logic [2*DataW-1:0] pb_q, pd_q;
  logic               bneg_q, dneg_q;

  logic [2*DataW-1:0]      rb, rd;
  logic signed [CoefW-1:0] bdt, ddt, a2, c2;
  logic signed [CoefW-1:0] den_q, k1_q, k2_q, k3_q;

  logic signed [ProdW-1:0] p1_q, p2_q, p3_q;
  logic signed [SumW-1:0]  num_q;

  logic [MagW-1:0]    mag_q;
  logic [CoefW-1:0]   dmag_q;
  logic               neg_q;
  logic               ovf_q;
  logic [CoefW-1:0]   rem_q;
  logic [DivBits-1:0] lo_q;
  logic [CoefW:0]     trial, diff;
  logic               ge;

  logic [DataW-1:0] y;
  logic             sat;
  logic             den_zero;

  assign bmag = cfg_i.coef_b[DataW-1] ? DataW'(-cfg_i.coef_b) : cfg_i.coef_b;
  assign dmul = cfg_i.coef_d[DataW-1] ? DataW'(-cfg_i.coef_d) : cfg_i.coef_d;

  assign rb  = pb_q + 64'h0000_0000_8000_0000;
  assign rd  = pd_q + 64'h0000_0000_8000_0000;
  assign bdt = bneg_q ? -$signed({3'b000, rb[2*DataW-1:DataW]})
                      :  $signed({3'b000, rb[2*DataW-1:DataW]});
  assign ddt = dneg_q ? -$signed({3'b000, rd[2*DataW-1:DataW]})
                      :  $signed({3'b000, rd[2*DataW-1:DataW]});
  assign a2  = {{2{cfg_i.coef_a[DataW-1]}}, cfg_i.coef_a, 1'b0};
  assign c2  = {{2{cfg_i.coef_c[DataW-1]}}, cfg_i.coef_c, 1'b0};

  assign den_zero = (den_q == '0);
  assign sts_o.den_zero = den_zero;

  assign trial = {rem_q, lo_q[DivBits-1]};
  assign ge    = (trial >= {1'b0, dmag_q});
  assign diff  = trial - {1'b0, dmag_q};

  always_comb begin
    sat = 1'b0;
    y   = lo_q;
    if (ovf_q) begin
      sat = 1'b1;
      y   = neg_q ? SatMin : SatMax;
    end else if (neg_q) begin
      if (lo_q > SatMin) begin
        sat = 1'b1;
        y   = SatMin;
      end else begin
        y = DataW'(-lo_q);
      end
    end else if (lo_q[DivBits-1]) begin
      sat = 1'b1;
      y   = SatMax;
    end
  end

  always_comb begin
    prev_in_d  = prev_in_q;
    prev_out_d = prev_out_q;
    if (reload_i) begin
      prev_in_d  = cfg_i.initial_input;
      prev_out_d = cfg_i.initial_output;
    end else if (cmd_i.finish && !den_zero) begin
      prev_in_d  = x_q;
      prev_out_d = y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_in_q  <= RstInitIn;
      prev_out_q <= RstInitOut;
    end else begin
      prev_in_q  <= prev_in_d;
      prev_out_q <= prev_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.calc_dt) begin
      pb_q   <= (2*DataW)'(bmag) * (2*DataW)'(cfg_i.step_time);
      pd_q   <= (2*DataW)'(dmul) * (2*DataW)'(cfg_i.step_time);
      bneg_q <= cfg_i.coef_b[DataW-1];
      dneg_q <= cfg_i.coef_d[DataW-1];
    end
    if (cmd_i.calc_coef) begin
      den_q <= a2 + bdt;
      k1_q  <= a2 - bdt;
      k2_q  <= c2 + ddt;
      k3_q  <= ddt - c2;
    end
    if (cmd_i.calc_mul) begin
      p1_q <= ProdW'(k1_q) * ProdW'(prev_out_q);
      p2_q <= ProdW'(k2_q) * ProdW'(x_q);
      p3_q <= ProdW'(k3_q) * ProdW'(prev_in_q);
    end
    if (cmd_i.calc_sum) begin
      num_q <= SumW'(p1_q) + SumW'(p2_q) + SumW'(p3_q);
    end
    if (cmd_i.calc_abs) begin
      mag_q  <= num_q[SumW-1] ? MagW'(-num_q) : MagW'(num_q);
      neg_q  <= num_q[SumW-1] ^ den_q[CoefW-1];
      dmag_q <= den_q[CoefW-1] ? CoefW'(-den_q) : CoefW'(den_q);
    end
    if (cmd_i.div_init) begin
      ovf_q <= (mag_q[MagW-1:DivBits] >= {1'b0, dmag_q});
      rem_q <= mag_q[DivBits+CoefW-1:DivBits];
      lo_q  <= mag_q[DivBits-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[CoefW-1:0] : trial[CoefW-1:0];
      lo_q  <= {lo_q[DivBits-2:0], ge};
    end
    if (cmd_i.finish) begin
      sample_out_o  <= den_zero ? '0 : y;
      saturated_o   <= den_zero ? 1'b0 : sat;
      bad_divisor_o <= den_zero;
    end
  end

endmodule
`default_nettype wire
